// ===== design/ppc_pkg.sv =====
// shared types and constants of the polygon plane clipper
// no dependencies; every other file of the block imports this package
`default_nettype none
package ppc_pkg;

  localparam int unsigned POS_FRAC_BITS = 16;
  localparam int unsigned T_FRAC_BITS   = 24;
  localparam int unsigned NUM_COMP      = 11;
  localparam int unsigned ADDR_W        = 5;

  localparam logic [63:0] EPS_RESET_W =
    ((64'd1 << (2 * POS_FRAC_BITS)) + 64'd500000) / 64'd1000000;
  localparam logic [31:0] EPS_RESET     = EPS_RESET_W[31:0];
  localparam logic [31:0] PLANE_D_RESET = 32'd1 << POS_FRAC_BITS;

  localparam logic [2:0] REG_PLANE_A = 3'd0;
  localparam logic [2:0] REG_PLANE_B = 3'd1;
  localparam logic [2:0] REG_PLANE_C = 3'd2;
  localparam logic [2:0] REG_PLANE_D = 3'd3;
  localparam logic [2:0] REG_EPS     = 3'd4;

  typedef struct packed {
    logic [3:0][31:0] pos;
    logic [2:0][15:0] nrm;
    logic [31:0]      rgba;
  } vtx_t;

  typedef struct packed {
    vtx_t        v;
    logic [63:0] dval;
    logic        last;
  } rec_t;

  typedef struct packed {
    vtx_t v;
    logic empty;
    logic eop;
  } res_t;

  typedef struct packed {
    logic [3:0][31:0] coef;
    logic [31:0]      eps;
  } cfg_t;

endpackage
`default_nettype wire

// ===== design/ppc_cfg.sv =====
// configuration registers behind the apb-style port
// depends on ppc_pkg
`default_nettype none
module ppc_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ppc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output ppc_pkg::cfg_t                    cfg_o
);
  import ppc_pkg::*;

  cfg_t       cfg_q;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef[0] <= '0;
      cfg_q.coef[1] <= '0;
      cfg_q.coef[2] <= '0;
      cfg_q.coef[3] <= PLANE_D_RESET;
      cfg_q.eps     <= EPS_RESET;
    end else if (wr) begin
      case (idx)
        REG_PLANE_A: cfg_q.coef[0] <= pwdata;
        REG_PLANE_B: cfg_q.coef[1] <= pwdata;
        REG_PLANE_C: cfg_q.coef[2] <= pwdata;
        REG_PLANE_D: cfg_q.coef[3] <= pwdata;
        REG_EPS:     cfg_q.eps     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PLANE_A: prdata = cfg_q.coef[0];
      REG_PLANE_B: prdata = cfg_q.coef[1];
      REG_PLANE_C: prdata = cfg_q.coef[2];
      REG_PLANE_D: prdata = cfg_q.coef[3];
      REG_EPS:     prdata = cfg_q.eps;
      default:     prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/ppc_front.sv =====
// front end: takes vertices, computes the plane distance, queues the record
// depends on ppc_pkg
`default_nettype none
module ppc_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire ppc_pkg::vtx_t vtx_i,
  input  wire logic          last_i,
  input  wire ppc_pkg::cfg_t cfg_i,
  output logic               q_valid_o,
  output ppc_pkg::rec_t      q_data_o,
  input  wire logic          q_pop_i
);
  import ppc_pkg::*;

  logic               busy_q;
  logic [2:0]         step_q;
  vtx_t               vtx_q;
  logic               last_q;
  logic signed [63:0] prod_q;
  logic [63:0]        acc_q;
  logic signed [64:0] sum;
  logic [63:0]        sat;
  logic               q_push;

  rec_t       mem_q [0:1];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full = busy_q;

  // saturating accumulate, same order as the products arrive
  always_comb begin
    sum = $signed({acc_q[63], acc_q}) + $signed({prod_q[63], prod_q});
    if (sum[64] != sum[63]) begin
      sat = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat = sum[63:0];
    end
  end

  assign q_push = busy_q && (step_q == 3'd5) && (cnt_q != 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (push && !full) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      if (step_q != 3'd5) begin
        step_q <= step_q + 3'd1;
      end else if (q_push) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && !full) begin
      vtx_q  <= vtx_i;
      last_q <= last_i;
      acc_q  <= '0;
    end else if (busy_q) begin
      if (step_q < 3'd4) begin
        prod_q <= $signed(cfg_i.coef[step_q[1:0]]) * $signed(vtx_q.pos[step_q[1:0]]);
      end
      if (step_q >= 3'd1 && step_q <= 3'd4) begin
        acc_q <= sat;
      end
    end
  end

  // two-entry queue toward the back end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (q_push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, q_push} - {1'b0, q_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_push) begin
      mem_q[wp_q] <= '{v: vtx_q, dval: acc_q, last: last_q};
    end
  end

  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = mem_q[rp_q];

endmodule
`default_nettype wire

// ===== design/ppc_back.sv =====
// back end: edge clipping sequencer with serial divider and shared lerp multiplier
// depends on ppc_pkg
`default_nettype none
module ppc_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ppc_pkg::cfg_t cfg_i,
  input  wire logic          q_valid_i,
  input  wire ppc_pkg::rec_t q_data_i,
  output logic               q_pop_o,
  output logic               out_push_o,
  output ppc_pkg::res_t      out_data_o,
  input  wire logic          out_full_i
);
  import ppc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_EDGE  = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_EMITL = 4'd5;
  localparam logic [3:0] S_EMITB = 4'd6;
  localparam logic [3:0] S_EDONE = 4'd7;
  localparam logic [3:0] S_FLUSH = 4'd8;

  logic [3:0] state_q;
  logic       mid_q, sel_q, held_v_q;
  rec_t       cur_q, first_q, prev_q;
  vtx_t       held_q, lerp_q;

  logic [63:0]            r_q, den_q;
  logic                   tz_q;
  logic [4:0]             div_cnt_q;
  logic [T_FRAC_BITS:0]   t_q;
  logic [3:0]             mul_cnt_q;
  logic signed [59:0]     prod_q;

  rec_t               ea, eb;
  logic               in_a, in_b, can_emit, ge;
  logic [64:0]        r2, r2s;
  logic               r2ge;
  logic [3:0]         ridx;
  logic signed [32:0] ca_c, cb_c, ca_r;
  logic signed [33:0] diff;
  logic signed [59:0] xr, qr, res;

  function automatic logic is_inside(logic [63:0] d, logic [31:0] eps);
    logic signed [65:0] s;
    s = $signed({{2{d[63]}}, d}) + $signed({34'd0, eps});
    return !s[65];
  endfunction

  function automatic logic signed [32:0] comp(vtx_t v, logic [3:0] i);
    logic signed [32:0] c;
    case (i)
      4'd0, 4'd1, 4'd2, 4'd3: c = $signed({v.pos[i[1:0]][31], v.pos[i[1:0]]});
      4'd4:  c = $signed({{17{v.nrm[0][15]}}, v.nrm[0]});
      4'd5:  c = $signed({{17{v.nrm[1][15]}}, v.nrm[1]});
      4'd6:  c = $signed({{17{v.nrm[2][15]}}, v.nrm[2]});
      4'd7:  c = $signed({25'd0, v.rgba[7:0]});
      4'd8:  c = $signed({25'd0, v.rgba[15:8]});
      4'd9:  c = $signed({25'd0, v.rgba[23:16]});
      4'd10: c = $signed({25'd0, v.rgba[31:24]});
      default: c = '0;
    endcase
    return c;
  endfunction

  assign ea   = sel_q ? cur_q : prev_q;
  assign eb   = sel_q ? first_q : cur_q;
  assign in_a = is_inside(ea.dval, cfg_i.eps);
  assign in_b = is_inside(eb.dval, cfg_i.eps);
  assign ge   = $signed(ea.dval) >= $signed(eb.dval);

  // one quotient bit per cycle
  assign r2   = {r_q, 1'b0};
  assign r2ge = r2 >= {1'b0, den_q};
  assign r2s  = r2 - {1'b0, den_q};

  assign ridx = mul_cnt_q - 4'd1;
  assign ca_c = comp(ea.v, mul_cnt_q);
  assign cb_c = comp(eb.v, mul_cnt_q);
  assign ca_r = comp(ea.v, ridx);
  assign diff = $signed({cb_c[32], cb_c}) - $signed({ca_c[32], ca_c});
  assign xr   = prod_q + $signed(60'd1 << (T_FRAC_BITS - 1));
  assign qr   = xr >>> T_FRAC_BITS;
  assign res  = $signed({{27{ca_r[32]}}, ca_r}) + qr;

  assign can_emit = !held_v_q || !out_full_i;
  assign q_pop_o  = (state_q == S_IDLE) && q_valid_i;

  always_comb begin
    out_push_o = 1'b0;
    out_data_o = '{v: held_q, empty: 1'b0, eop: 1'b0};
    case (state_q)
      S_EMITL, S_EMITB: out_push_o = held_v_q && !out_full_i;
      S_FLUSH: begin
        out_push_o = !out_full_i;
        out_data_o = '{v: held_v_q ? held_q : '0, empty: !held_v_q, eop: 1'b1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mid_q    <= 1'b0;
      sel_q    <= 1'b0;
      held_v_q <= 1'b0;
      div_cnt_q <= '0;
      mul_cnt_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) state_q <= S_START;
        end
        S_START: begin
          if (!mid_q) begin
            mid_q <= 1'b1;
            if (cur_q.last) begin
              sel_q   <= 1'b1;
              state_q <= S_EDGE;
            end else begin
              state_q <= S_IDLE;
            end
          end else begin
            sel_q   <= 1'b0;
            state_q <= S_EDGE;
          end
        end
        S_EDGE: begin
          div_cnt_q <= '0;
          if (in_a != in_b) state_q <= S_DIV;
          else if (in_b)    state_q <= S_EMITB;
          else              state_q <= S_EDONE;
        end
        S_DIV: begin
          mul_cnt_q <= '0;
          if (div_cnt_q == 5'd0 && (tz_q || den_q == 64'd0 || r_q >= den_q)) begin
            state_q <= S_MUL;
          end else if (div_cnt_q == 5'(T_FRAC_BITS - 1)) begin
            state_q <= S_MUL;
          end else begin
            div_cnt_q <= div_cnt_q + 5'd1;
          end
        end
        S_MUL: begin
          if (mul_cnt_q == 4'(NUM_COMP)) state_q <= S_EMITL;
          else mul_cnt_q <= mul_cnt_q + 4'd1;
        end
        S_EMITL: begin
          if (can_emit) begin
            held_v_q <= 1'b1;
            state_q  <= in_b ? S_EMITB : S_EDONE;
          end
        end
        S_EMITB: begin
          if (can_emit) begin
            held_v_q <= 1'b1;
            state_q  <= S_EDONE;
          end
        end
        S_EDONE: begin
          if (!sel_q && cur_q.last) begin
            sel_q   <= 1'b1;
            state_q <= S_EDGE;
          end else begin
            state_q <= cur_q.last ? S_FLUSH : S_IDLE;
          end
        end
        S_FLUSH: begin
          if (!out_full_i) begin
            held_v_q <= 1'b0;
            mid_q    <= 1'b0;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) cur_q <= q_data_i;
      end
      S_START: begin
        if (!mid_q) begin
          first_q <= cur_q;
          if (!cur_q.last) prev_q <= cur_q;
        end
      end
      S_EDGE: begin
        t_q <= '0;
        if (ge) begin
          tz_q  <= $signed(ea.dval) <= 64'sd0;
          r_q   <= ea.dval;
          den_q <= ea.dval - eb.dval;
        end else begin
          tz_q  <= $signed(ea.dval) >= 64'sd0;
          r_q   <= 64'd0 - ea.dval;
          den_q <= eb.dval - ea.dval;
        end
      end
      S_DIV: begin
        if (div_cnt_q == 5'd0 && (tz_q || den_q == 64'd0)) begin
          t_q <= '0;
        end else if (div_cnt_q == 5'd0 && r_q >= den_q) begin
          t_q <= (T_FRAC_BITS+1)'(1) << T_FRAC_BITS;
        end else begin
          r_q <= r2ge ? r2s[63:0] : r2[63:0];
          t_q <= {t_q[T_FRAC_BITS-1:0], r2ge};
        end
      end
      S_MUL: begin
        if (mul_cnt_q < 4'(NUM_COMP)) begin
          prod_q <= diff * $signed({1'b0, t_q});
        end
        if (mul_cnt_q != 4'd0) begin
          case (ridx)
            4'd0, 4'd1, 4'd2, 4'd3: lerp_q.pos[ridx[1:0]] <= res[31:0];
            4'd4:  lerp_q.nrm[0]       <= res[15:0];
            4'd5:  lerp_q.nrm[1]       <= res[15:0];
            4'd6:  lerp_q.nrm[2]       <= res[15:0];
            4'd7:  lerp_q.rgba[7:0]    <= res[7:0];
            4'd8:  lerp_q.rgba[15:8]   <= res[7:0];
            4'd9:  lerp_q.rgba[23:16]  <= res[7:0];
            4'd10: lerp_q.rgba[31:24]  <= res[7:0];
            default: ;
          endcase
        end
      end
      S_EMITL: begin
        if (can_emit) held_q <= lerp_q;
      end
      S_EMITB: begin
        if (can_emit) held_q <= eb.v;
      end
      S_EDONE: begin
        if (sel_q || !cur_q.last) prev_q <= cur_q;
      end
      default: ;
    endcase
  end

  a_push_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> !out_full_i) else $error("result pushed into a full queue");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i) else $error("vertex popped from an empty queue");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH && !out_full_i) |=> (!held_v_q && !mid_q))
    else $error("polygon flush left state behind");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (div_cnt_q < 5'(T_FRAC_BITS)))
    else $error("divider ran past its bit count");

endmodule
`default_nettype wire

// ===== design/ppc_oq.sv =====
// result queue that faces the consumer
// depends on ppc_pkg
`default_nettype none
module ppc_oq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire ppc_pkg::res_t data_i,
  output logic               full_o,
  output logic               empty,
  input  wire logic          pop,
  output ppc_pkg::res_t      data_o
);
  import ppc_pkg::*;

  res_t       mem_q [0:3];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic       do_pop;

  assign full_o = (cnt_q == 3'd4);
  assign empty  = (cnt_q == 3'd0);
  assign do_pop = pop && !empty;
  assign data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 2'd1;
      if (do_pop) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {2'd0, push_i} - {2'd0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

endmodule
`default_nettype wire

// ===== design/polygon_plane_clipper.sv =====
// Single-plane polygon clipper, one vertex per request. The front end takes a
// new vertex only once the record of the last one is queued, forming the plane
// distance with one 32x32 multiplier over four products, then parks the record
// in a two-entry queue. In the back end a crossing edge forms t with a serial
// divider (one quotient bit per cycle), runs the lerp on one shared multiplier
// over eleven components and then emits the crossing point. The last vertex
// also runs the closing edge back to the first vertex and a flush. Results
// wait in a four-entry queue. No clearing pass after reset.
// depends on ppc_pkg, ppc_cfg, ppc_front, ppc_back, ppc_oq
`default_nettype none
module polygon_plane_clipper (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ppc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [31:0]                pos_x_i,
  input  wire logic [31:0]                pos_y_i,
  input  wire logic [31:0]                pos_z_i,
  input  wire logic [31:0]                pos_w_i,
  input  wire logic [15:0]                normal_x_i,
  input  wire logic [15:0]                normal_y_i,
  input  wire logic [15:0]                normal_z_i,
  input  wire logic [31:0]                rgba_i,
  input  wire logic                       last_vertex_i,
  output logic                            empty,
  input  wire logic                       pop,
  output logic [31:0]                     out_x_o,
  output logic [31:0]                     out_y_o,
  output logic [31:0]                     out_z_o,
  output logic [31:0]                     out_w_o,
  output logic [15:0]                     out_normal_x_o,
  output logic [15:0]                     out_normal_y_o,
  output logic [15:0]                     out_normal_z_o,
  output logic [31:0]                     out_rgba_o,
  output logic                            polygon_empty_o,
  output logic                            end_of_polygon_o
);
  import ppc_pkg::*;

  cfg_t cfg;
  vtx_t in_vtx;
  rec_t q_data;
  res_t out_data, head;
  logic q_valid, q_pop, out_push, out_full;

  assign in_vtx.pos[0] = pos_x_i;
  assign in_vtx.pos[1] = pos_y_i;
  assign in_vtx.pos[2] = pos_z_i;
  assign in_vtx.pos[3] = pos_w_i;
  assign in_vtx.nrm[0] = normal_x_i;
  assign in_vtx.nrm[1] = normal_y_i;
  assign in_vtx.nrm[2] = normal_z_i;
  assign in_vtx.rgba   = rgba_i;

  ppc_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  ppc_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .vtx_i     (in_vtx),
    .last_i    (last_vertex_i),
    .cfg_i     (cfg),
    .q_valid_o (q_valid),
    .q_data_o  (q_data),
    .q_pop_i   (q_pop)
  );

  ppc_back u_back (
    .clk_i, .rst_ni,
    .cfg_i      (cfg),
    .q_valid_i  (q_valid),
    .q_data_i   (q_data),
    .q_pop_o    (q_pop),
    .out_push_o (out_push),
    .out_data_o (out_data),
    .out_full_i (out_full)
  );

  ppc_oq u_oq (
    .clk_i, .rst_ni,
    .push_i (out_push),
    .data_i (out_data),
    .full_o (out_full),
    .empty,
    .pop,
    .data_o (head)
  );

  assign out_x_o          = head.v.pos[0];
  assign out_y_o          = head.v.pos[1];
  assign out_z_o          = head.v.pos[2];
  assign out_w_o          = head.v.pos[3];
  assign out_normal_x_o   = head.v.nrm[0];
  assign out_normal_y_o   = head.v.nrm[1];
  assign out_normal_z_o   = head.v.nrm[2];
  assign out_rgba_o       = head.v.rgba;
  assign polygon_empty_o  = head.empty;
  assign end_of_polygon_o = head.eop;

endmodule
`default_nettype wire
